// File: src/etic_pkg.sv
// Shared constants, types and register codes of the escape-time iteration counter.
`timescale 1ns / 1ps
package etic_pkg;

	// Field widths fixed by the channel definitions
	localparam int unsigned C_W        = 32;
	localparam int unsigned TAG_W      = 24;
	localparam int unsigned CNT_W      = 10;
	localparam int unsigned LIM_W      = 4;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_LIM  = 2'd1;

	localparam logic [CNT_W-1:0] MAX_ITER_RST = 10'd200;
	localparam logic [LIM_W-1:0] ESC_LIM_RST  = 4'd4;

	// Arithmetic format defaults (Q4.28)
	localparam int unsigned FRAC_BITS_DEF = 28;
	localparam int unsigned WORD_BITS_DEF = 32;

	typedef struct packed {
		logic [CNT_W-1:0] max_iterations;
		logic [LIM_W-1:0] escape_limit_sq;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RI,
		ST_UPD,
		ST_RR,
		ST_II,
		ST_CMP,
		ST_OUT
	} core_st_t;

endpackage

// File: src/etic_in_if.sv
// Point channel: valid/ready handshake carrying c and the pixel tag.
`timescale 1ns / 1ps
interface etic_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [etic_pkg::C_W-1:0]   c_real;
	logic signed [etic_pkg::C_W-1:0]   c_imag;
	logic        [etic_pkg::TAG_W-1:0] pixel_tag;

	modport source(output valid, c_real, c_imag, pixel_tag, input ready);
	modport sink(input valid, c_real, c_imag, pixel_tag, output ready);
endinterface

// File: src/etic_out_if.sv
// Result channel: valid/ready handshake carrying the escape count and tag.
`timescale 1ns / 1ps
interface etic_out_if;
	logic                              valid;
	logic                              ready;
	logic        [etic_pkg::CNT_W-1:0] escape_count;
	logic                              escaped;
	logic        [etic_pkg::TAG_W-1:0] tag_out;

	modport source(output valid, escape_count, escaped, tag_out, input ready);
	modport sink(input valid, escape_count, escaped, tag_out, output ready);
endinterface

// File: src/etic_front.sv
// Front end: accept points, fit c to the word format, flag empty runs, queue them.
`timescale 1ns / 1ps
module etic_front #(
	parameter int unsigned WORD_BITS = etic_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	etic_in_if.sink                          points,
	input  logic [etic_pkg::CNT_W-1:0]       max_iterations,
	output logic                             q_vld,
	input  logic                             q_rdy,
	output logic [2*WORD_BITS+etic_pkg::TAG_W:0] q_data
);
	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned CW = etic_pkg::C_W;
	localparam int unsigned QW = 2*W + etic_pkg::TAG_W + 1;

	logic signed [W-1:0] cr;
	logic signed [W-1:0] ci;
	logic                skip;
	logic                push;
	logic                pop;
	logic [QW-1:0]       ent_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;

	generate
		if (W >= CW) begin : g_wide
			always_comb begin
				cr = W'(points.c_real);
				ci = W'(points.c_imag);
			end
		end else begin : g_narrow
			localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
			localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
			logic [CW-W:0] top_r;
			logic [CW-W:0] top_i;
			always_comb begin
				top_r = points.c_real[CW-1:W-1];
				top_i = points.c_imag[CW-1:W-1];
				if (top_r == '0 || top_r == '1) begin
					cr = points.c_real[W-1:0];
				end else begin
					cr = points.c_real[CW-1] ? MINV : MAXV;
				end
				if (top_i == '0 || top_i == '1) begin
					ci = points.c_imag[W-1:0];
				end else begin
					ci = points.c_imag[CW-1] ? MINV : MAXV;
				end
			end
		end
	endgenerate

	// A point with no iterations to run goes straight to the result
	assign skip = (max_iterations == '0);

	assign points.ready = (cnt_q != 2'd2);
	assign q_vld        = (cnt_q != 2'd0);
	assign q_data       = ent_q[rd_q];
	assign push         = points.valid & points.ready;
	assign pop          = q_vld & q_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= {skip, points.pixel_tag, ci, cr};
		end
	end

endmodule

// File: src/etic_mul.sv
// Shared signed multiplier: one product per request, in four partial products on 32-bit halves above 32 bits.
`timescale 1ns / 1ps
module etic_mul #(
	parameter int unsigned WORD_BITS = etic_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [WORD_BITS-1:0]   a,
	input  logic signed [WORD_BITS-1:0]   b,
	output logic                          done,
	output logic signed [2*WORD_BITS-1:0] prod
);
	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned AW = 2*W;
	localparam int unsigned NP = (W > 32) ? 4 : 1;
	localparam int unsigned OW = 33;
	localparam int unsigned PW = 2*OW;
	localparam int unsigned EW = AW + PW;

	logic signed [W-1:0]  a_q;
	logic signed [W-1:0]  b_q;
	logic [1:0]           k_q;
	logic                 busy_q;
	logic signed [OW-1:0] op_a;
	logic signed [OW-1:0] op_b;
	logic [1:0]           sh;
	logic signed [PW-1:0] prod_s1;
	logic [1:0]           sh_s1;
	logic                 vld_s1;
	logic                 last_s1;
	logic signed [EW-1:0] part;
	logic signed [AW-1:0] acc_q;
	logic                 done_q;
	logic                 last;

	generate
		if (NP == 4) begin : g_split
			// Upper half signed, lower half unsigned
			always_comb begin
				op_a = k_q[1] ? {{(OW-(W-32)){a_q[W-1]}}, a_q[W-1:32]} : {1'b0, a_q[31:0]};
				op_b = k_q[0] ? {{(OW-(W-32)){b_q[W-1]}}, b_q[W-1:32]} : {1'b0, b_q[31:0]};
				sh   = {1'b0, k_q[1]} + {1'b0, k_q[0]};
			end
		end else begin : g_single
			always_comb begin
				op_a = {{(OW-W){a_q[W-1]}}, a_q};
				op_b = {{(OW-W){b_q[W-1]}}, b_q};
				sh   = 2'd0;
			end
		end
	endgenerate

	assign last = (k_q == 2'(NP-1));
	assign part = EW'(prod_s1) <<< (32*sh_s1);
	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= 2'd0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= vld_s1 & last_s1;
			vld_s1 <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= 2'd0;
			end else if (busy_q) begin
				last_s1 <= last;
				k_q     <= k_q + 2'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + part[AW-1:0];
		end
		if (busy_q) begin
			prod_s1 <= op_a * op_b;
			sh_s1   <= sh;
		end
	end

endmodule

// File: src/etic_core.sv
// Back end: iterate z = z*z + c on the shared multiplier and hold the result.
`timescale 1ns / 1ps
module etic_core #(
	parameter int unsigned WORD_BITS = etic_pkg::WORD_BITS_DEF,
	parameter int unsigned FRAC_BITS = etic_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  etic_pkg::cfg_t                       cfg,
	input  logic                                 q_vld,
	output logic                                 q_rdy,
	input  logic [2*WORD_BITS+etic_pkg::TAG_W:0] q_data,
	etic_out_if.source                           results
);
	localparam int unsigned W   = WORD_BITS;
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned TW  = etic_pkg::TAG_W;
	localparam int unsigned NW  = etic_pkg::CNT_W;
	localparam int unsigned DW  = 2*W + 1;
	localparam int unsigned SW  = 2*W + 2;
	localparam int unsigned MW  = (2*W + 1 > 2*F + 4) ? 2*W + 1 : 2*F + 4;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	etic_pkg::core_st_t st_q, st_d;

	logic                   pend_q;
	logic                   mul_start;
	logic                   mul_done;
	logic signed [W-1:0]    mul_a;
	logic signed [W-1:0]    mul_b;
	logic signed [2*W-1:0]  mul_p;
	logic signed [W-1:0]    cr_q, ci_q, zr_q, zi_q;
	logic signed [2*W-1:0]  rr_q, ii_q, ri_q;
	logic signed [DW-1:0]   dif_q;
	logic [TW-1:0]          tag_q;
	logic [NW-1:0]          it_q;
	logic [NW-1:0]          cnt_q;
	logic                   esc_q;
	logic signed [SW-1:0]   sum_r, sum_i;
	logic [MW-1:0]          mag, lim;
	logic                   escape;
	logic                   last;
	logic                   load_out;
	logic                   out_vld_q;

	function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] s);
		logic [SW-W:0] top;
		top = s[SW-1:W-1];
		if (top == '0 || top == '1) begin
			return s[W-1:0];
		end
		return s[SW-1] ? MINV : MAXV;
	endfunction

	etic_mul #(.WORD_BITS(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	always_comb begin
		mul_a = zr_q;
		mul_b = zi_q;
		case (st_q)
			etic_pkg::ST_RR: mul_b = zr_q;
			etic_pkg::ST_II: mul_a = zi_q;
			default: ;
		endcase
	end

	assign sum_r  = (SW'(dif_q) >>> F) + SW'(cr_q);
	assign sum_i  = (SW'(ri_q) >>> (F-1)) + SW'(ci_q);
	assign mag    = MW'($unsigned(rr_q)) + MW'($unsigned(ii_q));
	assign lim    = MW'(cfg.escape_limit_sq) << (2*F);
	assign escape = (mag > lim);
	assign last   = (NW'(it_q + 1'b1) == cfg.max_iterations);

	always_comb begin
		st_d      = st_q;
		q_rdy     = 1'b0;
		mul_start = 1'b0;
		load_out  = 1'b0;
		case (st_q)
			etic_pkg::ST_IDLE: begin
				if (q_vld) begin
					q_rdy = 1'b1;
					st_d  = q_data[2*W+TW] ? etic_pkg::ST_OUT : etic_pkg::ST_RI;
				end
			end
			etic_pkg::ST_RI: begin
				mul_start = !pend_q;
				if (mul_done) begin
					st_d = etic_pkg::ST_UPD;
				end
			end
			etic_pkg::ST_UPD: st_d = etic_pkg::ST_RR;
			etic_pkg::ST_RR: begin
				mul_start = !pend_q;
				if (mul_done) begin
					st_d = etic_pkg::ST_II;
				end
			end
			etic_pkg::ST_II: begin
				mul_start = !pend_q;
				if (mul_done) begin
					st_d = etic_pkg::ST_CMP;
				end
			end
			etic_pkg::ST_CMP: begin
				st_d = (escape || last) ? etic_pkg::ST_OUT : etic_pkg::ST_RI;
			end
			etic_pkg::ST_OUT: begin
				if (!out_vld_q || results.ready) begin
					load_out = 1'b1;
					st_d     = etic_pkg::ST_IDLE;
				end
			end
			default: st_d = etic_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= etic_pkg::ST_IDLE;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (mul_start) begin
				pend_q <= 1'b1;
			end else if (mul_done) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			etic_pkg::ST_IDLE: begin
				if (q_vld) begin
					cr_q  <= q_data[W-1:0];
					ci_q  <= q_data[2*W-1:W];
					tag_q <= q_data[2*W+TW-1:2*W];
					zr_q  <= '0;
					zi_q  <= '0;
					rr_q  <= '0;
					ii_q  <= '0;
					it_q  <= '0;
					cnt_q <= '0;
					esc_q <= 1'b0;
				end
			end
			etic_pkg::ST_RI: begin
				dif_q <= DW'(rr_q) - DW'(ii_q);
				if (mul_done) begin
					ri_q <= mul_p;
				end
			end
			etic_pkg::ST_UPD: begin
				zr_q <= sat_w(sum_r);
				zi_q <= sat_w(sum_i);
			end
			etic_pkg::ST_RR: begin
				if (mul_done) begin
					rr_q <= mul_p;
				end
			end
			etic_pkg::ST_II: begin
				if (mul_done) begin
					ii_q <= mul_p;
				end
			end
			etic_pkg::ST_CMP: begin
				if (escape) begin
					cnt_q <= it_q;
					esc_q <= 1'b1;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (load_out) begin
			results.escape_count <= cnt_q;
			results.escaped      <= esc_q;
			results.tag_out      <= tag_q;
		end
	end

	assign results.valid = out_vld_q;

endmodule

// File: src/escape_time_iteration_counter_unit.sv
// Top level of the escape-time iteration counter: config registers, front end, back end.
`timescale 1ns / 1ps
// Usage
//   points  : sink channel; one item carries c_real, c_imag (signed, FRAC_BITS fraction
//             bits) and a pixel_tag. An item is taken at a clock edge with valid and ready.
//   results : source channel; one item per point with escape_count, escaped and the
//             unchanged tag, in the order the points arrived.
//   cfg_*   : write port; index 0 sets max_iterations, index 1 sets escape_limit_sq.
//             Write only while no point is in flight. Other indexes are dropped.
// Operation
//   The back end runs one point at a time on a single shared multiplier. Each iteration
//   takes three products (re*im, re^2, im^2) of P partial products each, where P is 1 for
//   WORD_BITS up to 32 and 4 above, plus one update and one compare step. A point runs
//   escape index + 1 iterations, or max_iterations if it never escapes.
//   A two-item queue in front lets up to two more points be accepted while one iterates.
// Reset
//   arst_n clears the queue, the sequencer and the result valid; max_iterations returns
//   to 200 and escape_limit_sq to 4.
// Stall
//   A result waits in the output register until taken; meanwhile the back end holds its
//   finished point and the front queue keeps accepting until it is full.
module escape_time_iteration_counter_unit #(
	parameter int unsigned FRAC_BITS = etic_pkg::FRAC_BITS_DEF,
	parameter int unsigned WORD_BITS = etic_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	etic_in_if.sink                             points,
	etic_out_if.source                          results,
	input  logic                                cfg_we,
	input  logic [etic_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [etic_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	localparam int unsigned QW = 2*WORD_BITS + etic_pkg::TAG_W + 1;

	etic_pkg::cfg_t cfg_q;
	logic           q_vld;
	logic           q_rdy;
	logic [QW-1:0]  q_data;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations  <= etic_pkg::MAX_ITER_RST;
			cfg_q.escape_limit_sq <= etic_pkg::ESC_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				etic_pkg::REG_MAX_ITER: cfg_q.max_iterations <= cfg_wdata[etic_pkg::CNT_W-1:0];
				etic_pkg::REG_ESC_LIM:  cfg_q.escape_limit_sq <= cfg_wdata[etic_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: accept, fit c to the word format, queue
	etic_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.points         (points),
		.max_iterations (cfg_q.max_iterations),
		.q_vld          (q_vld),
		.q_rdy          (q_rdy),
		.q_data         (q_data)
	);

	// Back: iterate and drive the result register
	etic_core #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_vld   (q_vld),
		.q_rdy   (q_rdy),
		.q_data  (q_data),
		.results (results)
	);

endmodule

// File: verif/etic_escape_checker.sv
`timescale 1ns / 1ps
// Checker for the escape-time counter: tracks the registers, predicts each result and compares.
module etic_escape_checker #(
	parameter int unsigned FRAC_BITS = etic_pkg::FRAC_BITS_DEF,
	parameter int unsigned WORD_BITS = etic_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	etic_in_if                              points,
	etic_out_if                             results,
	input  logic                            cfg_we,
	input  logic [etic_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [etic_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              mismatches,
	output int                              outstanding
);
	import etic_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [CNT_W-1:0] escape_count;
		logic             escaped;
		logic [TAG_W-1:0] tag;
	} escape_rec_t;

	localparam wide_t WORD_MAX = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
	localparam wide_t WORD_MIN = -(wide_t'(1) <<< (WORD_BITS - 1));

	cfg_t        regs_now;
	escape_rec_t owed_escapes[$];

	function automatic wide_t clamp_word(input wide_t v);
		if (v > WORD_MAX)
			return WORD_MAX;
		if (v < WORD_MIN)
			return WORD_MIN;
		return v;
	endfunction

	// Iterate z = z*z + c from z = 0 and find the first index where |z|^2 passes the limit.
	function automatic escape_rec_t escape_of_point(input logic signed [C_W-1:0] cre, cim,
			input logic [TAG_W-1:0] tag, input cfg_t regs);
		wide_t       cr, ci, zr, zi, nr, ni, mag, bound;
		escape_rec_t r;
		int unsigned i;
		cr = clamp_word(wide_t'(cre));
		ci = clamp_word(wide_t'(cim));
		zr = 0;
		zi = 0;
		bound = wide_t'(regs.escape_limit_sq) <<< (2 * FRAC_BITS);
		r.escape_count = '0;
		r.escaped = 1'b0;
		r.tag = tag;
		i = 0;
		while (i < regs.max_iterations && !r.escaped) begin
			nr = clamp_word(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
			ni = clamp_word(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
			zr = nr;
			zi = ni;
			mag = nr * nr + ni * ni;
			if (mag > bound) begin
				r.escape_count = CNT_W'(i);
				r.escaped = 1'b1;
			end
			i++;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		escape_rec_t want;
		if (!arst_n) begin
			regs_now.max_iterations = MAX_ITER_RST;
			regs_now.escape_limit_sq = ESC_LIM_RST;
			owed_escapes.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MAX_ITER: regs_now.max_iterations = cfg_wdata[CNT_W-1:0];
					REG_ESC_LIM:  regs_now.escape_limit_sq = cfg_wdata[LIM_W-1:0];
					default: ;
				endcase
			end
			if (points.valid && points.ready)
				owed_escapes.push_back(escape_of_point(points.c_real, points.c_imag,
					points.pixel_tag, regs_now));
			if (results.valid && results.ready) begin
				if (owed_escapes.size() == 0) begin
					report_mismatch($sformatf("result tag %h with nothing outstanding",
						results.tag_out));
				end else begin
					want = owed_escapes.pop_front();
					if (results.escape_count !== want.escape_count)
						report_mismatch($sformatf("tag %h escape_count %0d, want %0d",
							want.tag, results.escape_count, want.escape_count));
					if (results.escaped !== want.escaped)
						report_mismatch($sformatf("tag %h escaped %b, want %b",
							want.tag, results.escaped, want.escaped));
					if (results.tag_out !== want.tag)
						report_mismatch($sformatf("tag_out %h, want %h",
							results.tag_out, want.tag));
				end
			end
			outstanding = owed_escapes.size();
		end
	end

endmodule

// File: verif/escape_time_iteration_counter_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the escape-time counter: clock, reset, point stimulus and the verdict.
module escape_time_iteration_counter_unit_tb;
	import etic_pkg::*;

	localparam int unsigned FRAC = FRAC_BITS_DEF;
	// One in the Q4.28 word format
	localparam int ONE = 1 << FRAC;
	localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
	localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};
	// Indexes with no register behind them; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef enum int {
		PACE_FREE,
		PACE_SEND,
		PACE_RECV,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic signed [C_W-1:0] re;
		logic signed [C_W-1:0] im;
	} point_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    send_idle_pct = 0;
	int                    recv_stall_pct = 0;
	int                    mismatches;
	int                    outstanding;

	etic_in_if  points_ch();
	etic_out_if results_ch();

	escape_time_iteration_counter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.points   (points_ch),
		.results  (results_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	etic_escape_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.points     (points_ch),
		.results    (results_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: drop ready at random according to the current pace
	always @(posedge clk) begin
		results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hard stop, set at several times the slowest correct run, even with every point
	// running to its iteration limit.
	initial begin
		#80_000_000;
		$display("status: fail");
		$finish;
	end

	// Corner values of one coordinate: the word limits, zero, one LSB either side, radius 2, or a random word
	function automatic logic signed [C_W-1:0] edge_value();
		case ($urandom_range(6))
			0: return C_MAX;
			1: return C_MIN;
			2: return 0;
			3: return 1;
			4: return -1;
			5: return $urandom_range(1) ? 2 * ONE : -2 * ONE;
			default: return $urandom;
		endcase
	endfunction

	// Mix of points: the whole plane (mostly quick escapes), the set's bounding box,
	// jittered points on the boundary (long, uneven runs), the interior (full runs)
	// and corner values.
	function automatic point_t pick_point();
		point_t p;
		int     kind;
		int     jit_re;
		int     jit_im;
		kind = $urandom_range(99);
		jit_re = int'($urandom_range(1 << 21)) - (1 << 20);
		jit_im = int'($urandom_range(1 << 21)) - (1 << 20);
		if (kind < 20) begin
			p.re = $urandom;
			p.im = $urandom;
		end else if (kind < 55) begin
			p.re = int'($urandom_range(4 * ONE)) - 2 * ONE;
			p.im = int'($urandom_range(3 * ONE)) - 3 * ONE / 2;
		end else if (kind < 75) begin
			case ($urandom_range(5))
				// neck between the main cardioid and the period-2 bulb
				0: begin
					p.re = -3 * ONE / 4;
					p.im = 0;
				end
				// cusp of the cardioid
				1: begin
					p.re = ONE / 4;
					p.im = 0;
				end
				// tip of the antenna on the negative real axis
				2: begin
					p.re = -2 * ONE;
					p.im = 0;
				end
				3: begin
					p.re = -5 * ONE / 4;
					p.im = 0;
				end
				4: begin
					p.re = 0;
					p.im = ONE;
				end
				default: begin
					p.re = -ONE / 8;
					p.im = 3 * ONE / 4;
				end
			endcase
			p.re = p.re + jit_re;
			p.im = p.im + jit_im;
		end else if (kind < 88) begin
			p.re = int'($urandom_range(ONE / 2)) - ONE / 4;
			p.im = int'($urandom_range(ONE / 2)) - ONE / 4;
		end else begin
			p.re = edge_value();
			p.im = edge_value();
		end
		return p;
	endfunction

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FREE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND: begin
				send_idle_pct = 59;
				recv_stall_pct = 0;
			end
			PACE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 59;
			end
			default: begin
				send_idle_pct = 11;
				recv_stall_pct = 11;
			end
		endcase
	endtask

	// Offer one point; return at the edge where it is taken. valid stays high into the next
	// item unless the sender decides to idle first.
	task automatic send_point(input logic signed [C_W-1:0] re, input logic signed [C_W-1:0] im,
			input logic [TAG_W-1:0] tag);
		while ($urandom_range(99) < send_idle_pct) begin
			points_ch.valid <= 1'b0;
			@(posedge clk);
		end
		points_ch.valid     <= 1'b1;
		points_ch.c_real    <= re;
		points_ch.c_imag    <= im;
		points_ch.pixel_tag <= tag;
		@(posedge clk);
		while (!points_ch.ready)
			@(posedge clk);
	endtask

	// Hold off the sender until every point sent so far has its result back, then let the
	// compare stage settle before anyone touches the registers.
	task automatic drain();
		points_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// One setting of the registers, then a batch of random points. The pace changes every
	// 25 items so that gaps land on every stage of the iteration.
	task automatic run_phase(input logic [CNT_W-1:0] iters, input logic [LIM_W-1:0] lim,
			input int count);
		point_t                p;
		logic [CFG_DATA_W-1:0] data;
		int                    start;
		drain();
		write_reg(REG_MAX_ITER, CFG_DATA_W'(iters));
		// Upper bits of the data word must be ignored by the 4-bit limit register
		data = CFG_DATA_W'($urandom);
		data[LIM_W-1:0] = lim;
		write_reg(REG_ESC_LIM, data);
		write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
		// The origin never grows; one LSB escapes at once only with a zero limit
		set_pace(PACE_FREE);
		send_point(0, 0, TAG_W'($urandom));
		send_point(1, 0, TAG_W'($urandom));
		start = $urandom_range(3);
		for (int n = 0; n < count; n++) begin
			if (n % 25 == 0)
				set_pace(pace_t'((start + n / 25) % 4));
			p = pick_point();
			send_point(p.re, p.im, TAG_W'($urandom));
		end
	endtask

	initial begin
		points_ch.valid     <= 1'b0;
		points_ch.c_real    <= '0;
		points_ch.c_imag    <= '0;
		points_ch.pixel_tag <= '0;
		cfg_we              <= 1'b0;
		cfg_idx             <= REG_MAX_ITER;
		cfg_wdata           <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed points at the reset setting (200 iterations, limit 4)
		set_pace(PACE_FREE);
		send_point(0, 0, 24'h000000);
		send_point(C_MAX, C_MAX, 24'hFFFFFF);
		send_point(C_MIN, C_MIN, TAG_W'($urandom));
		send_point(C_MAX, C_MIN, TAG_W'($urandom));
		send_point(C_MIN, C_MAX, TAG_W'($urandom));
		send_point(C_MIN, 0, TAG_W'($urandom));
		send_point(0, C_MAX, TAG_W'($urandom));
		// Sits exactly on the radius and never passes it
		send_point(-2 * ONE, 0, TAG_W'($urandom));
		// Reach |z|^2 = 4 first, escape one step later
		send_point(2 * ONE, 0, TAG_W'($urandom));
		send_point(0, 2 * ONE, TAG_W'($urandom));
		// 1, 2, 5: escapes at index 2
		send_point(ONE, 0, TAG_W'($urandom));
		// Short cycles that stay bounded
		send_point(-ONE, 0, TAG_W'($urandom));
		send_point(0, ONE, TAG_W'($urandom));
		// Cusp, and just outside it where the escape takes many steps
		send_point(ONE / 4, 0, TAG_W'($urandom));
		send_point(ONE / 4 + ONE / 64, 0, TAG_W'($urandom));
		send_point(-3 * ONE / 4, ONE / 16, TAG_W'($urandom));
		send_point(1, 0, TAG_W'($urandom));
		send_point(-1, -1, TAG_W'($urandom));

		// Settings include the extremes: one iteration, none, a zero limit, the
		// widest limit, the longest run and the reset values again.
		run_phase(10'd1, 4'd4, 150);
		run_phase(10'd0, 4'd4, 40);
		run_phase(10'd16, 4'd0, 200);
		run_phase(10'd32, 4'd15, 250);
		run_phase(10'd8, 4'd4, 300);
		run_phase(10'd64, 4'd2, 200);
		run_phase(10'd1023, 4'd15, 10);
		run_phase(MAX_ITER_RST, ESC_LIM_RST, 60);
		run_phase(10'd5, 4'd9, 290);

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
